FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cpcc_pkg.sv
// crank power / cadence calculator: shared types and constants
// no dependencies
package cpcc_pkg;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_PULSE  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic REG_UPDATE_PERIOD = 1'b0;
    localparam logic REG_TORQUE        = 1'b1;

    localparam logic [15:0] UPDATE_PERIOD_RST = 16'd250;
    localparam logic [19:0] TORQUE_RST        = 20'd112508;

    // two pi in q16 times 1000
    localparam logic [31:0] K_SCALE      = 32'd411775000;
    localparam logic [32:0] CADENCE_BIAS = 33'd120000;
    localparam logic [15:0] SAMPLE_MAX   = 16'hFFFF;

    localparam int QUOT_W = 16;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 48;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KMUL,
        ST_DMUL,
        ST_PP0,
        ST_PP1,
        ST_PP2,
        ST_PP3,
        ST_PP4,
        ST_PDIV,
        ST_PWAIT,
        ST_CDIV,
        ST_CWAIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: hw/rtl/cpcc_item_if.sv
// input item channel: op, weight sample and time
// no dependencies
interface cpcc_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [23:0] weight_sample;
    logic [31:0]        time_ms;

    modport source (output valid, op, weight_sample, time_ms, input ready);
    modport sink (input valid, op, weight_sample, time_ms, output ready);
endinterface

FILE: hw/rtl/cpcc_result_if.sv
// result channel: published power and cadence values
// no dependencies
interface cpcc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] inst_power;
    logic [15:0] acc_power;
    logic [7:0]  event_count;
    logic [7:0]  cadence_rpm;

    modport source (output valid, inst_power, acc_power, event_count, cadence_rpm,
                    input ready);
    modport sink (input valid, inst_power, acc_power, event_count, cadence_rpm,
                  output ready);
endinterface

FILE: hw/rtl/cpcc_div.sv
// iterative restoring divider, 16-bit quotient saturating at all ones
// depends on cpcc_pkg
module cpcc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cpcc_pkg::div_req_t req,
    output cpcc_pkg::div_rsp_t rsp
);
    import cpcc_pkg::*;

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(QUOT_W);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'(QUOT_W))
                begin
                    if (ge)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    cnt_reg <= cnt_reg - 5'd1;
                end
                else if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            dsh_reg  <= {req.den, {QUOT_W{1'b0}}};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'(QUOT_W))
            begin
                // quotient would not fit: saturate
                if (ge)
                    quot_reg <= '1;
                dsh_reg <= dsh_reg >> 1;
            end
            else
            begin
                if (ge)
                    rem_reg <= rem_reg - dsh_reg;
                quot_reg <= {quot_reg[QUOT_W-2:0], ge};
                dsh_reg  <= dsh_reg >> 1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: hw/rtl/crank_power_cadence_calc_top.sv
// crank power and cadence calculator, top level
// depends on cpcc_pkg, cpcc_item_if, cpcc_result_if, cpcc_div, assert_macros.svh
//
// Weight samples and ticks are handled on transfer. For a crank pulse the shared
// 32x32 multiplier builds the divisor and the scaled weight product, then the
// shared divider runs once for power (skipped when no samples arrived) and once
// for cadence; a saturating quotient finishes its division early. Input is
// not ready while a pulse is in work. A published result sits in an output register,
// and input is not ready while that result waits and the receiver is not ready.
`include "assert_macros.svh"

module crank_power_cadence_calc_top (
    input  logic           clk,
    input  logic           rst_n,
    cpcc_item_if.sink      item,
    cpcc_result_if.source  result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import cpcc_pkg::*;

    state_t      state_reg;
    state_t      state_next;

    logic [15:0] update_period_reg;
    logic [19:0] torque_reg;

    logic [31:0] last_pulse_reg;
    logic [39:0] weight_total_reg;
    logic [15:0] sample_count_reg;
    logic [15:0] power_now_reg;
    logic [15:0] power_sum_reg;
    logic [7:0]  pulse_count_reg;
    logic [7:0]  cadence_now_reg;
    logic [31:0] next_publish_reg;

    logic [31:0] per_reg;
    logic [31:0] time_hold_reg;
    logic [48:0] k_reg;
    logic [47:0] d_reg;
    logic [89:0] acc_reg;
    logic [63:0] mul_reg;
    logic [15:0] pwr_res_reg;

    logic        result_valid_reg;
    logic [15:0] out_inst_reg;
    logic [15:0] out_acc_reg;
    logic [7:0]  out_count_reg;
    logic [7:0]  out_cad_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] period;
    logic        item_xfer;
    logic        cfg_wr;
    logic        publish;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    cpcc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TORQUE) ? {12'd0, torque_reg} : {16'd0, update_period_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_period_reg <= UPDATE_PERIOD_RST;
            torque_reg        <= TORQUE_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_UPDATE_PERIOD)
                update_period_reg <= pwdata[15:0];
            else
                torque_reg <= pwdata[19:0];
        end
    end

    assign item.ready = (state_reg == ST_IDLE) && (!result_valid_reg || result.ready);
    assign item_xfer  = item.valid && item.ready;
    assign period     = ((item.time_ms - last_pulse_reg) == 32'd0) ? 32'd1
                                                                    : item.time_ms - last_pulse_reg;
    assign publish    = item_xfer && (item.op == OP_TICK) && (item.time_ms > next_publish_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer && item.op == OP_PULSE)
                    state_next = ST_KMUL;
            end
            ST_KMUL:
            begin
                mul_a      = {12'd0, torque_reg};
                mul_b      = K_SCALE;
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                mul_a      = {16'd0, sample_count_reg};
                mul_b      = per_reg;
                state_next = ST_PP0;
            end
            ST_PP0:
            begin
                mul_a      = {12'd0, weight_total_reg[19:0]};
                mul_b      = {7'd0, k_reg[24:0]};
                state_next = ST_PP1;
            end
            ST_PP1:
            begin
                mul_a      = {12'd0, weight_total_reg[19:0]};
                mul_b      = {8'd0, k_reg[48:25]};
                state_next = ST_PP2;
            end
            ST_PP2:
            begin
                mul_a      = {12'd0, weight_total_reg[39:20]};
                mul_b      = {7'd0, k_reg[24:0]};
                state_next = ST_PP3;
            end
            ST_PP3:
            begin
                mul_a      = {12'd0, weight_total_reg[39:20]};
                mul_b      = {8'd0, k_reg[48:25]};
                state_next = ST_PP4;
            end
            ST_PP4:
            begin
                state_next = ST_PDIV;
            end
            ST_PDIV:
            begin
                if (sample_count_reg != 16'd0)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {15'd0, acc_reg[89:41]};
                    div_req.den   = d_reg;
                    state_next    = ST_PWAIT;
                end
                else
                begin
                    state_next = ST_CDIV;
                end
            end
            ST_PWAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_CDIV;
            end
            ST_CDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = {31'd0, CADENCE_BIAS + {1'b0, per_reg}};
                div_req.den   = {15'd0, per_reg, 1'b0};
                state_next    = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // shared multiplier and pulse datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        if (item_xfer && item.op == OP_PULSE)
        begin
            per_reg       <= period;
            time_hold_reg <= item.time_ms;
        end
        unique case (state_reg)
            ST_DMUL:  k_reg <= mul_reg[48:0];
            ST_PP0:
            begin
                d_reg   <= mul_reg[47:0];
                acc_reg <= {2'd0, mul_reg[47:0], 40'd0};
            end
            ST_PP1:   acc_reg <= acc_reg + ({45'd0, mul_reg[44:0]} << 1);
            ST_PP2:   acc_reg <= acc_reg + ({46'd0, mul_reg[43:0]} << 26);
            ST_PP3:   acc_reg <= acc_reg + ({45'd0, mul_reg[44:0]} << 21);
            ST_PP4:   acc_reg <= acc_reg + ({46'd0, mul_reg[43:0]} << 46);
            ST_PDIV:
            begin
                if (sample_count_reg == 16'd0)
                    pwr_res_reg <= 16'd0;
            end
            ST_PWAIT:
            begin
                if (div_rsp.done)
                    pwr_res_reg <= div_rsp.quot;
            end
            default:
            begin
            end
        endcase
    end

    // block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pulse_reg   <= '0;
            weight_total_reg <= '0;
            sample_count_reg <= '0;
            power_now_reg    <= '0;
            power_sum_reg    <= '0;
            pulse_count_reg  <= '0;
            cadence_now_reg  <= '0;
            next_publish_reg <= '0;
        end
        else
        begin
            if (item_xfer && item.op == OP_SAMPLE && sample_count_reg != SAMPLE_MAX)
            begin
                if (!item.weight_sample[23])
                    weight_total_reg <= weight_total_reg + {16'd0, item.weight_sample};
                sample_count_reg <= sample_count_reg + 16'd1;
            end
            if (publish)
                next_publish_reg <= next_publish_reg + {16'd0, update_period_reg};
            if (state_reg == ST_CWAIT && div_rsp.done)
            begin
                cadence_now_reg  <= (div_rsp.quot > 16'd255) ? 8'd255 : div_rsp.quot[7:0];
                power_now_reg    <= pwr_res_reg;
                power_sum_reg    <= power_sum_reg + pwr_res_reg;
                pulse_count_reg  <= pulse_count_reg + 8'd1;
                last_pulse_reg   <= time_hold_reg;
                weight_total_reg <= '0;
                sample_count_reg <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (publish)
            result_valid_reg <= 1'b1;
        else if (result.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            out_inst_reg  <= power_now_reg;
            out_acc_reg   <= power_sum_reg;
            out_count_reg <= pulse_count_reg;
            out_cad_reg   <= cadence_now_reg;
        end
    end

    assign result.valid       = result_valid_reg;
    assign result.inst_power  = out_inst_reg;
    assign result.acc_power   = out_acc_reg;
    assign result.event_count = out_count_reg;
    assign result.cadence_rpm = out_cad_reg;

    `ASSERT_IMPLIES(a_empty_sum, sample_count_reg == 16'd0, weight_total_reg == 40'd0,
        "weight sum nonzero with no samples")
    `ASSERT_NEXT(a_pulse_starts, item.valid && item.ready && item.op == OP_PULSE,
        state_reg == ST_KMUL, "pulse transfer did not start the sequencer")
    `ASSERT_IMPLIES(a_result_from_tick, $rose(result_valid_reg),
        $past(item.valid && item.ready && item.op == OP_TICK), "result without tick transfer")

endmodule
